FILE: design/trr_pkg.sv
// Shared types, constants and helpers for the transition graph reachability block.
`timescale 1ns / 1ps

package trr_pkg;

    localparam int MAX_VALUES = 64;
    localparam int VAL_W      = 6;
    localparam int CNT_W      = 7;
    localparam int KIND_W     = 2;
    localparam int VERDICT_W  = 2;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [KIND_W-1:0] KIND_ARC    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MARK   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FINISH = 2'd2;

    localparam logic [VERDICT_W-1:0] VERDICT_KEPT    = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_REMOVED = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_TRUE    = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [VAL_W-1:0]  from_value;
        logic [VAL_W-1:0]  to_value;
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] size;
        logic [VAL_W-1:0] start_value;
    } t_cfg;

    function automatic logic [MAX_VALUES-1:0] size_mask(input logic [CNT_W-1:0] size);
        logic [MAX_VALUES-1:0] m;
        for (int i = 0; i < MAX_VALUES; i++) begin
            m[i] = (CNT_W'(i) < size);
        end
        return m;
    endfunction

endpackage

FILE: design/transition_graph_reach_renumber.sv
// Top level of the transition graph reachability and renumbering block.
`timescale 1ns / 1ps

// Channel    Direction  Signals                                     Transfer
// command    in         start, i_kind, i_from_value, i_to_value     start && !busy
// config     in         i_cfg_we, i_cfg_index, i_cfg_data           i_cfg_we
// result     out        o_strobe, o_value_index, o_verdict,         o_strobe
//                       o_new_index, o_last
//
// A four-entry queue decouples command accept from the graph engine, which applies arc
// and mark commands; busy is high while the queue is full.
// After a finish is taken off the queue, the walk reads one adjacency row per reached
// value, plus a wait whenever the next row depends on a read in flight; then one result
// is shown for each value of the domain.
// Reset is synchronous; row valid bits clear the adjacency memory at once, no sweep.
// The receiver cannot stall: each result is shown for exactly one cycle.

module transition_graph_reach_renumber (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [trr_pkg::KIND_W-1:0]    i_kind,
    input  logic [trr_pkg::VAL_W-1:0]     i_from_value,
    input  logic [trr_pkg::VAL_W-1:0]     i_to_value,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [trr_pkg::CNT_W-1:0]     i_cfg_data,
    output logic                          o_strobe,
    output logic [trr_pkg::VAL_W-1:0]     o_value_index,
    output logic [trr_pkg::VERDICT_W-1:0] o_verdict,
    output logic [trr_pkg::VAL_W-1:0]     o_new_index,
    output logic                          o_last
);
    import trr_pkg::*;

    logic push;
    logic pop;
    logic full;
    logic empty;
    t_cmd cmd;
    t_cmd head;
    t_cfg cfg;

    assign busy = full;

    trr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_kind       (i_kind),
        .i_from_value (i_from_value),
        .i_to_value   (i_to_value),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_full       (full),
        .o_push       (push),
        .o_cmd        (cmd),
        .o_cfg        (cfg)
    );

    trr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_full  (full)
    );

    trr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_empty       (empty),
        .i_head        (head),
        .o_pop         (pop),
        .o_strobe      (o_strobe),
        .o_value_index (o_value_index),
        .o_verdict     (o_verdict),
        .o_new_index   (o_new_index),
        .o_last        (o_last)
    );

endmodule

FILE: design/trr_front.sv
// Front end: configuration registers, command accept and range filtering.
`timescale 1ns / 1ps

module trr_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    input  logic [trr_pkg::KIND_W-1:0] i_kind,
    input  logic [trr_pkg::VAL_W-1:0]  i_from_value,
    input  logic [trr_pkg::VAL_W-1:0]  i_to_value,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [trr_pkg::CNT_W-1:0]  i_cfg_data,
    input  logic                       i_full,
    output logic                       o_push,
    output trr_pkg::t_cmd              o_cmd,
    output trr_pkg::t_cfg              o_cfg
);
    import trr_pkg::*;

    localparam logic CFG_VALUE_COUNT = 1'b0;
    localparam logic CFG_START_VALUE = 1'b1;

    logic [CNT_W-1:0] r_value_count;
    logic [VAL_W-1:0] r_start_value;
    logic [CNT_W-1:0] size;
    logic             accept;
    logic             from_ok;
    logic             to_ok;
    logic             keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value_count <= CNT_W'(MAX_VALUES);
            r_start_value <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_VALUE_COUNT: r_value_count <= i_cfg_data;
                CFG_START_VALUE: r_start_value <= i_cfg_data[VAL_W-1:0];
                default: ;
            endcase
        end
    end

    assign size = (r_value_count > CNT_W'(MAX_VALUES)) ? CNT_W'(MAX_VALUES) : r_value_count;

    assign accept  = start && !i_full;
    assign from_ok = ({1'b0, i_from_value} < size);
    assign to_ok   = ({1'b0, i_to_value} < size);

    // Arcs and marks that fall outside the domain, self-loops and unused kinds
    // are dropped here so the back end never sees them.
    always_comb begin
        case (i_kind)
            KIND_ARC:    keep = from_ok && to_ok && (i_from_value != i_to_value);
            KIND_MARK:   keep = to_ok;
            KIND_FINISH: keep = 1'b1;
            default:     keep = 1'b0;
        endcase
    end

    assign o_push            = accept && keep;
    assign o_cmd.kind        = i_kind;
    assign o_cmd.from_value  = i_from_value;
    assign o_cmd.to_value    = i_to_value;
    assign o_cfg.size        = size;
    assign o_cfg.start_value = r_start_value;

endmodule

FILE: design/trr_fifo.sv
// Short command queue between the front end and the graph engine.
`timescale 1ns / 1ps

module trr_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  trr_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output trr_pkg::t_cmd o_head,
    output logic          o_empty,
    output logic          o_full
);
    import trr_pkg::*;

    t_cmd                r_slot [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  r_wr_ptr;
    logic [FIFO_AW-1:0]  r_rd_ptr;
    logic [FIFO_AW:0]    r_fill;
    logic [FIFO_AW-1:0]  n_wr_ptr;
    logic [FIFO_AW-1:0]  n_rd_ptr;
    logic [FIFO_AW:0]    n_fill;

    assign o_empty = (r_fill == '0);
    assign o_full  = (r_fill == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_head  = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr + (i_push ? FIFO_AW'(1) : '0);
        n_rd_ptr = r_rd_ptr + (i_pop ? FIFO_AW'(1) : '0);
        n_fill   = r_fill + (i_push ? (FIFO_AW+1)'(1) : '0) - (i_pop ? (FIFO_AW+1)'(1) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

FILE: design/trr_back.sv
// Graph engine: adjacency memory, reachability walk and renumbering output.
`timescale 1ns / 1ps

module trr_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  trr_pkg::t_cfg                 i_cfg,
    input  logic                          i_empty,
    input  trr_pkg::t_cmd                 i_head,
    output logic                          o_pop,
    output logic                          o_strobe,
    output logic [trr_pkg::VAL_W-1:0]     o_value_index,
    output logic [trr_pkg::VERDICT_W-1:0] o_verdict,
    output logic [trr_pkg::VAL_W-1:0]     o_new_index,
    output logic                          o_last
);
    import trr_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [MAX_VALUES-1:0] r_adj [MAX_VALUES];

    logic [1:0]            r_state,      n_state;
    logic [MAX_VALUES-1:0] r_row_valid,  n_row_valid;
    logic [MAX_VALUES-1:0] r_uncond,     n_uncond;
    logic [MAX_VALUES-1:0] r_reached,    n_reached;
    logic [MAX_VALUES-1:0] r_pending,    n_pending;
    logic [CNT_W-1:0]      r_count,      n_count;
    logic                  r_rd_valid,   n_rd_valid;
    logic                  r_rd_row_ok,  n_rd_row_ok;
    logic                  r_out_strobe, n_out_strobe;
    logic [CNT_W-1:0]      r_emit_v,     n_emit_v;
    logic [VAL_W-1:0]      r_new_idx,    n_new_idx;
    logic [VAL_W-1:0]      r_out_value,  n_out_value;
    logic [VERDICT_W-1:0]  r_out_verdict, n_out_verdict;
    logic [VAL_W-1:0]      r_out_index,  n_out_index;
    logic                  r_out_last,   n_out_last;
    logic [MAX_VALUES-1:0] r_rd_data;

    logic [MAX_VALUES-1:0] mask;
    logic [MAX_VALUES-1:0] start_oh;
    logic [MAX_VALUES-1:0] iso;
    logic [VAL_W-1:0]      sel_idx;
    logic [MAX_VALUES-1:0] new_bits;
    logic                  rd_issue;
    logic                  wr_en;
    logic                  pop;

    assign mask     = size_mask(i_cfg.size);
    assign start_oh = ({1'b0, i_cfg.start_value} < i_cfg.size) ?
                      (MAX_VALUES'(1) << i_cfg.start_value) : '0;

    // Lowest pending value is expanded next; each reached value is expanded once.
    assign iso = r_pending & (~r_pending + MAX_VALUES'(1));

    always_comb begin
        sel_idx = '0;
        for (int i = 0; i < MAX_VALUES; i++) begin
            if (iso[i]) begin
                sel_idx = sel_idx | VAL_W'(i);
            end
        end
    end

    assign new_bits = r_rd_valid ?
                      ((r_rd_row_ok ? r_rd_data : '0) & mask & ~r_reached) : '0;

    always_comb begin
        n_state       = r_state;
        n_row_valid   = r_row_valid;
        n_uncond      = r_uncond;
        n_reached     = r_reached;
        n_pending     = r_pending;
        n_count       = r_count;
        n_rd_row_ok   = r_row_valid[sel_idx];
        n_out_strobe  = 1'b0;
        n_emit_v      = r_emit_v;
        n_new_idx     = r_new_idx;
        n_out_value   = r_out_value;
        n_out_verdict = r_out_verdict;
        n_out_index   = r_out_index;
        n_out_last    = r_out_last;
        rd_issue      = 1'b0;
        wr_en         = 1'b0;
        pop           = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    pop = 1'b1;
                    case (i_head.kind)
                        KIND_ARC: begin
                            wr_en = 1'b1;
                            n_row_valid[i_head.from_value] = 1'b1;
                        end
                        KIND_MARK: begin
                            n_uncond = r_uncond | (MAX_VALUES'(1) << i_head.to_value);
                        end
                        KIND_FINISH: begin
                            n_reached = (r_uncond & mask) | start_oh;
                            n_pending = (r_uncond & mask) | start_oh;
                            n_count   = '0;
                            n_state   = S_WALK;
                        end
                        default: ;
                    endcase
                end
            end
            S_WALK: begin
                n_reached = r_reached | new_bits;
                if (r_pending != '0) begin
                    rd_issue  = 1'b1;
                    n_count   = r_count + CNT_W'(1);
                    n_pending = (r_pending & ~iso) | new_bits;
                end else begin
                    n_pending = new_bits;
                    if (!r_rd_valid) begin
                        n_emit_v  = '0;
                        n_new_idx = '0;
                        if (i_cfg.size == '0) begin
                            n_state     = S_IDLE;
                            n_row_valid = '0;
                            n_uncond    = '0;
                            n_reached   = '0;
                            n_pending   = '0;
                        end else begin
                            n_state = S_EMIT;
                        end
                    end
                end
            end
            S_EMIT: begin
                n_out_strobe = 1'b1;
                n_out_value  = r_emit_v[VAL_W-1:0];
                n_out_index  = '0;
                n_out_last   = ((r_emit_v + CNT_W'(1)) == i_cfg.size);
                if (r_count == CNT_W'(1)) begin
                    n_out_verdict = (r_emit_v == {1'b0, i_cfg.start_value}) ?
                                    VERDICT_TRUE : VERDICT_REMOVED;
                end else if (r_reached[r_emit_v[VAL_W-1:0]]) begin
                    n_out_verdict = VERDICT_KEPT;
                    n_out_index   = r_new_idx;
                    n_new_idx     = r_new_idx + VAL_W'(1);
                end else begin
                    n_out_verdict = VERDICT_REMOVED;
                end
                n_emit_v = r_emit_v + CNT_W'(1);
                if ((r_emit_v + CNT_W'(1)) == i_cfg.size) begin
                    // The run is over: arcs, marks and walk state start fresh.
                    n_state     = S_IDLE;
                    n_row_valid = '0;
                    n_uncond    = '0;
                    n_reached   = '0;
                    n_pending   = '0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_rd_valid = rd_issue;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_row_valid  <= '0;
            r_uncond     <= '0;
            r_reached    <= '0;
            r_pending    <= '0;
            r_count      <= '0;
            r_rd_valid   <= 1'b0;
            r_out_strobe <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_row_valid  <= n_row_valid;
            r_uncond     <= n_uncond;
            r_reached    <= n_reached;
            r_pending    <= n_pending;
            r_count      <= n_count;
            r_rd_valid   <= n_rd_valid;
            r_out_strobe <= n_out_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_row_ok   <= n_rd_row_ok;
        r_emit_v      <= n_emit_v;
        r_new_idx     <= n_new_idx;
        r_out_value   <= n_out_value;
        r_out_verdict <= n_out_verdict;
        r_out_index   <= n_out_index;
        r_out_last    <= n_out_last;
    end

    // Adjacency memory with per-bit write. A row that is not valid holds stale
    // data, so its first arc rewrites the whole row.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            if (r_row_valid[i_head.from_value]) begin
                r_adj[i_head.from_value][i_head.to_value] <= 1'b1;
            end else begin
                r_adj[i_head.from_value] <= MAX_VALUES'(1) << i_head.to_value;
            end
        end
        if (rd_issue) begin
            r_rd_data <= r_adj[sel_idx];
        end
    end

    assign o_pop         = pop;
    assign o_strobe      = r_out_strobe;
    assign o_value_index = r_out_value;
    assign o_verdict     = r_out_verdict;
    assign o_new_index   = r_out_index;
    assign o_last        = r_out_last;

`ifndef SYNTHESIS
    a_pending_reached: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending & ~r_reached) == '0)
        else $error("pending value not marked as reached");

    a_emit_unbroken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |=> o_strobe)
        else $error("result run broken before its last transfer");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_VALUES))
        else $error("expansion count exceeds domain size");

    a_read_only_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_WALK) |-> !r_rd_valid)
        else $error("adjacency read in flight outside the walk");
`endif

endmodule

FILE: tb/transition_graph_reach_renumber_tb.sv
// Self-checking testbench for the transition graph reachability and renumbering block.
`timescale 1ns / 1ps

module transition_graph_reach_renumber_tb;
    import trr_pkg::*;

    localparam logic [KIND_W-1:0] KIND_SPARE      = 2'd3;
    localparam logic              REG_VALUE_COUNT = 1'b0;
    localparam logic              REG_START_VALUE = 1'b1;
    localparam int                SETTLE_CYCLES   = 160;
    localparam int                CYCLE_LIMIT     = 400000;

    typedef enum logic [1:0] {STIM_CMD, STIM_REG, STIM_SETTLE} t_stim_what;

    typedef struct {
        t_stim_what        what;
        logic [KIND_W-1:0] kind;
        logic [VAL_W-1:0]  from_value;
        logic [VAL_W-1:0]  to_value;
        logic              reg_index;
        logic [CNT_W-1:0]  reg_data;
        int                idle_pct;
    } t_stim;

    typedef struct packed {
        logic [VAL_W-1:0]     value_index;
        logic [VERDICT_W-1:0] verdict;
        logic [VAL_W-1:0]     new_index;
        logic                 last;
    } t_renum;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [KIND_W-1:0]    i_kind = '0;
    logic [VAL_W-1:0]     i_from_value = '0;
    logic [VAL_W-1:0]     i_to_value = '0;
    logic                 i_cfg_we = 1'b0;
    logic                 i_cfg_index = 1'b0;
    logic [CNT_W-1:0]     i_cfg_data = '0;
    logic                 o_strobe;
    logic [VAL_W-1:0]     o_value_index;
    logic [VERDICT_W-1:0] o_verdict;
    logic [VAL_W-1:0]     o_new_index;
    logic                 o_last;

    transition_graph_reach_renumber dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_from_value  (i_from_value),
        .i_to_value    (i_to_value),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_strobe      (o_strobe),
        .o_value_index (o_value_index),
        .o_verdict     (o_verdict),
        .o_new_index   (o_new_index),
        .o_last        (o_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow copy of the graph, the marks and the two registers.
    logic [MAX_VALUES-1:0] arc_rows [MAX_VALUES];
    logic [MAX_VALUES-1:0] uncond_vals;
    logic [CNT_W-1:0]      cur_count;
    logic [VAL_W-1:0]      cur_start;

    t_stim  stim_q[$];
    t_renum renumber_q[$];

    int errors = 0;
    int cycles = 0;
    int n_cmds = 0;
    int n_finishes = 0;
    int n_results = 0;
    int n_reg_writes = 0;
    int sender_idle_pct = 0;
    int settle_cycles = 0;
    bit settle_wait = 1'b0;

    task automatic clear_graph_model();
        for (int i = 0; i < MAX_VALUES; i++) begin
            arc_rows[i] = '0;
        end
        uncond_vals = '0;
    endtask

    task automatic walk_and_renumber();
        int size;
        int count;
        int counter;
        logic [MAX_VALUES-1:0] mask;
        logic [MAX_VALUES-1:0] reached;
        logic [MAX_VALUES-1:0] frontier;
        logic [MAX_VALUES-1:0] grown;
        t_renum r;
        size = (cur_count > MAX_VALUES) ? MAX_VALUES : int'(cur_count);
        mask = (size >= MAX_VALUES) ? {MAX_VALUES{1'b1}} : ((64'd1 << size) - 64'd1);
        reached = uncond_vals & mask;
        if (cur_start < size) begin
            reached[cur_start] = 1'b1;
        end
        frontier = reached;
        for (int iter = 0; iter <= size && frontier != '0; iter++) begin
            grown = '0;
            for (int v = 0; v < size; v++) begin
                if (frontier[v]) begin
                    grown |= arc_rows[v];
                end
            end
            grown &= mask & ~reached;
            reached |= grown;
            frontier = grown;
        end
        count = $countones(reached);
        counter = 0;
        for (int v = 0; v < size; v++) begin
            r.value_index = VAL_W'(v);
            r.new_index = '0;
            // A single reachable value means the variable never changes.
            if (count == 1) begin
                r.verdict = (v == cur_start) ? VERDICT_TRUE : VERDICT_REMOVED;
            end else if (reached[v]) begin
                r.verdict = VERDICT_KEPT;
                r.new_index = VAL_W'(counter);
                counter++;
            end else begin
                r.verdict = VERDICT_REMOVED;
            end
            r.last = (v + 1 == size);
            renumber_q = {renumber_q, r};
        end
        clear_graph_model();
    endtask

    task automatic apply_command(input logic [KIND_W-1:0] kind,
                                 input logic [VAL_W-1:0] from_v,
                                 input logic [VAL_W-1:0] to_v);
        int size;
        size = (cur_count > MAX_VALUES) ? MAX_VALUES : int'(cur_count);
        case (kind)
            KIND_ARC: begin
                if (from_v < size && to_v < size && from_v != to_v) begin
                    arc_rows[from_v][to_v] = 1'b1;
                end
            end
            KIND_MARK: begin
                if (to_v < size) begin
                    uncond_vals[to_v] = 1'b1;
                end
            end
            KIND_FINISH: begin
                n_finishes++;
                walk_and_renumber();
            end
            default: ;
        endcase
    endtask

    // Driver: one transfer per cycle at most, fed from stim_q.
    always @(posedge i_clk) begin : driver
        t_stim nxt;
        logic  go_start;
        logic  go_reg;
        if (!i_rst_n) begin
            start <= 1'b0;
            i_cfg_we <= 1'b0;
            clear_graph_model();
            cur_count = CNT_W'(MAX_VALUES);
            cur_start = '0;
        end else begin
            if (start && !busy) begin
                n_cmds++;
                apply_command(i_kind, i_from_value, i_to_value);
            end
            if (i_cfg_we) begin
                n_reg_writes++;
                if (i_cfg_index == REG_VALUE_COUNT) begin
                    cur_count = i_cfg_data;
                end else begin
                    cur_start = i_cfg_data[VAL_W-1:0];
                end
            end
            if (!(start && busy)) begin
                go_start = 1'b0;
                go_reg = 1'b0;
                if (settle_cycles > 0) begin
                    settle_cycles--;
                end else if (settle_wait) begin
                    // Hold off until all results are in, then let trailing arcs drain.
                    if (renumber_q.size() == 0) begin
                        settle_wait = 1'b0;
                        settle_cycles = SETTLE_CYCLES;
                    end
                end else if (stim_q.size() != 0) begin
                    case (stim_q[0].what)
                        STIM_CMD: begin
                            if ($urandom_range(99) >= sender_idle_pct) begin
                                nxt = stim_q.pop_front();
                                go_start = 1'b1;
                            end
                        end
                        STIM_REG: begin
                            nxt = stim_q.pop_front();
                            go_reg = 1'b1;
                        end
                        default: begin
                            nxt = stim_q.pop_front();
                            settle_wait = 1'b1;
                            sender_idle_pct = nxt.idle_pct;
                        end
                    endcase
                end
                if (go_start) begin
                    i_kind <= nxt.kind;
                    i_from_value <= nxt.from_value;
                    i_to_value <= nxt.to_value;
                end else begin
                    i_kind <= KIND_W'($urandom);
                    i_from_value <= VAL_W'($urandom);
                    i_to_value <= VAL_W'($urandom);
                end
                if (go_reg) begin
                    i_cfg_index <= nxt.reg_index;
                    i_cfg_data <= nxt.reg_data;
                end else begin
                    i_cfg_index <= 1'($urandom);
                    i_cfg_data <= CNT_W'($urandom);
                end
                start <= go_start;
                i_cfg_we <= go_reg;
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_renum want;
        if (i_rst_n && o_strobe) begin
            if (renumber_q.size() == 0) begin
                errors++;
                if (errors <= 40) begin
                    $display("%0t: expected no result, actual value %0d verdict %0d index %0d",
                             $time, o_value_index, o_verdict, o_new_index);
                end
            end else begin
                want = renumber_q.pop_front();
                n_results++;
                if (o_value_index !== want.value_index || o_verdict !== want.verdict ||
                    o_new_index !== want.new_index || o_last !== want.last) begin
                    errors++;
                    if (errors <= 40) begin
                        $display("%0t: mismatch: expected value %0d verdict %0d index %0d last %0d",
                                 $time, want.value_index, want.verdict, want.new_index,
                                 want.last);
                        $display("%0t:           actual   value %0d verdict %0d index %0d last %0d",
                                 $time, o_value_index, o_verdict, o_new_index, o_last);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: no progress after %0d cycles, %0d results outstanding",
                     $time, cycles, renumber_q.size());
            $display("simulation failed");
            $finish;
        end
    end

    task automatic push_cmd(input logic [KIND_W-1:0] kind, input int from_v, input int to_v);
        t_stim s;
        s.what = STIM_CMD;
        s.kind = kind;
        s.from_value = VAL_W'(from_v);
        s.to_value = VAL_W'(to_v);
        s.reg_index = 1'b0;
        s.reg_data = '0;
        s.idle_pct = 0;
        stim_q = {stim_q, s};
    endtask

    task automatic push_reg(input logic index, input int data);
        t_stim s;
        s.what = STIM_REG;
        s.kind = KIND_ARC;
        s.from_value = '0;
        s.to_value = '0;
        s.reg_index = index;
        s.reg_data = CNT_W'(data);
        s.idle_pct = 0;
        stim_q = {stim_q, s};
    endtask

    task automatic push_settle(input int idle_pct);
        t_stim s;
        s.what = STIM_SETTLE;
        s.kind = KIND_ARC;
        s.from_value = '0;
        s.to_value = '0;
        s.reg_index = 1'b0;
        s.reg_data = '0;
        s.idle_pct = idle_pct;
        stim_q = {stim_q, s};
    endtask

    // Mostly arcs that grow a tree out of the seed, so walks go several levels deep;
    // the rest is out-of-domain arcs, self-loops, marks and spare-kind noise.
    task automatic queue_graph(input int size, input int seed_val, input int n_ops);
        int touched[$];
        int pick;
        int f;
        int t;
        if (size > 0) begin
            touched = {touched, ((seed_val < size) ? seed_val : int'($urandom_range(size - 1)))};
        end
        repeat (n_ops) begin
            pick = $urandom_range(99);
            if (size > 0 && pick < 60) begin
                f = touched[$urandom_range(touched.size() - 1)];
                t = $urandom_range(size - 1);
                push_cmd(KIND_ARC, f, t);
                touched = {touched, t};
            end else if (size > 0 && pick < 72) begin
                t = $urandom_range(size - 1);
                push_cmd(KIND_MARK, $urandom_range(63), t);
                touched = {touched, t};
            end else if (pick < 84) begin
                push_cmd(KIND_ARC, $urandom_range(63), $urandom_range(63));
            end else if (pick < 90) begin
                t = $urandom_range(63);
                push_cmd(KIND_ARC, t, t);
            end else if (pick < 95) begin
                push_cmd(KIND_MARK, $urandom_range(63), $urandom_range(63));
            end else begin
                push_cmd(KIND_SPARE, $urandom_range(63), $urandom_range(63));
            end
        end
        push_cmd(KIND_FINISH, $urandom_range(63), $urandom_range(63));
    endtask

    initial begin : stimulus
        int idle_pattern[3];
        int size;
        int count_reg;
        int start_reg;
        int budget;
        int n_ops;
        idle_pattern[0] = 0;
        idle_pattern[1] = 84;
        idle_pattern[2] = 15;

        // Full domain: arcs at the extremes, a self-loop, a mark, a spare kind.
        push_cmd(KIND_ARC, 0, 63);
        push_cmd(KIND_ARC, 63, 31);
        push_cmd(KIND_ARC, 17, 17);
        push_cmd(KIND_MARK, 63, 42);
        push_cmd(KIND_SPARE, 63, 63);
        push_cmd(KIND_FINISH, 63, 63);
        // Empty graph: only the start value is reachable.
        push_cmd(KIND_FINISH, 0, 0);
        // Start outside a small domain, out-of-domain loads: nothing reachable.
        push_settle(0);
        push_reg(REG_VALUE_COUNT, 10);
        push_reg(REG_START_VALUE, 7'h40 | 40);
        push_cmd(KIND_ARC, 3, 12);
        push_cmd(KIND_MARK, 0, 50);
        push_cmd(KIND_FINISH, 21, 42);
        // One reachable value that is not the start: all removed.
        push_cmd(KIND_MARK, 0, 2);
        push_cmd(KIND_FINISH, 0, 0);
        // Empty domain: a finish yields nothing.
        push_settle(0);
        push_reg(REG_VALUE_COUNT, 0);
        push_cmd(KIND_ARC, 0, 1);
        push_cmd(KIND_FINISH, 0, 0);
        // Oversized domain count and start at the top value.
        push_settle(0);
        push_reg(REG_VALUE_COUNT, 127);
        push_reg(REG_START_VALUE, 63);
        push_cmd(KIND_ARC, 63, 0);
        push_cmd(KIND_ARC, 0, 1);
        push_cmd(KIND_MARK, 0, 5);
        push_cmd(KIND_FINISH, 63, 0);
        // Single-value domain.
        push_settle(0);
        push_reg(REG_VALUE_COUNT, 1);
        push_reg(REG_START_VALUE, 0);
        push_cmd(KIND_FINISH, 0, 0);

        for (int p = 0; p < 8; p++) begin
            push_settle(idle_pattern[p % 3]);
            case ($urandom_range(9))
                0: count_reg = $urandom_range(65, 127);
                1: count_reg = 64;
                2: count_reg = 1;
                default: count_reg = $urandom_range(2, 63);
            endcase
            size = (count_reg > MAX_VALUES) ? MAX_VALUES : count_reg;
            start_reg = ($urandom_range(99) < 15) ? $urandom_range(63)
                                                  : $urandom_range(size - 1);
            push_reg(REG_VALUE_COUNT, count_reg);
            push_reg(REG_START_VALUE, ($urandom_range(1) << VAL_W) | start_reg);
            budget = 30;
            while (budget > 0) begin
                n_ops = ($urandom_range(7) == 0) ? $urandom_range(20, 40)
                                                 : $urandom_range(2, 12);
                queue_graph(size, start_reg, n_ops);
                budget -= n_ops + 1;
            end
        end
        push_settle(0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (stim_q.size() != 0 || start || settle_wait || settle_cycles != 0 ||
               renumber_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d commands with %0d finishes and %0d register writes;",
                 n_cmds, n_finishes, n_reg_writes);
        $display("checked %0d renumbering results under several sender idle patterns.",
                 n_results);
        if (errors == 0 && renumber_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
